// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/raid5_map_pkg.sv
// Types and fixed widths for the RAID-5 request mapper.
// Depends on nothing; imported by raid5_request_mapper.
`default_nettype none

package raid5_map_pkg;

    localparam int ADDR_W  = 20;
    localparam int DISK_W  = 3;
    localparam int CYL_W   = 10;
    localparam int HEAD_W  = 2;
    localparam int SEC_W   = 6;
    localparam int STAMP_W = 32;

    localparam logic CMD_READ  = 1'b1;
    localparam logic CMD_WRITE = 1'b0;

    // Request being issued for the word in the result register.
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

endpackage

`default_nettype wire

// File: rtl/core/raid5_request_mapper.sv
// A word passes through stage 0, stage 1 and stage 2 into the result register, which shows
// its first request; a stall can hold it in any stage. A read word gives one request, a write word three; the result
// register issues one disk request per cycle while out_stall is low and holds the word until its last.
// Stripe split uses reciprocal multiplies over two pipeline stages.
// Reset clears all valid flags, the request sequencer and the stamp counter.
// Depends on raid5_map_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module raid5_request_mapper
    import raid5_map_pkg::*;
#(
    parameter int unsigned DATA_DISKS        = 4,
    parameter int unsigned HEADS             = 4,
    parameter int unsigned SECTORS_PER_TRACK = 64,
    parameter int unsigned CYLINDERS         = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [ADDR_W-1:0]  address,
    input  wire logic               cmd,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DISK_W-1:0]       disk_index,
    output logic [CYL_W-1:0]        cylinder,
    output logic [HEAD_W-1:0]       head,
    output logic [SEC_W-1:0]        sector,
    output logic                    is_write,
    output logic [STAMP_W-1:0]      stamp,
    output logic                    last
);

    localparam int PW     = $clog2(DATA_DISKS + 1);
    localparam int SW     = $clog2(SECTORS_PER_TRACK + 1);
    localparam int HW     = $clog2(HEADS + 1);
    localparam int CW     = $clog2(CYLINDERS + 1);
    localparam int MW     = ADDR_W + 2;
    localparam int PROD_W = ADDR_W + MW;

    localparam longint unsigned DIV_STRIPE = longint'(DATA_DISKS);
    localparam longint unsigned DIV_PAR    = longint'(DATA_DISKS) + 1;
    localparam longint unsigned DIV_TRK    = longint'(SECTORS_PER_TRACK);
    localparam longint unsigned DIV_CYL    = longint'(HEADS) * longint'(SECTORS_PER_TRACK);
    localparam longint unsigned DIV_WRAP   = DIV_CYL * longint'(CYLINDERS);

    localparam int SH_STRIPE = ADDR_W + $clog2(DIV_STRIPE);
    localparam int SH_PAR    = ADDR_W + $clog2(DIV_PAR);
    localparam int SH_TRK    = ADDR_W + $clog2(DIV_TRK);
    localparam int SH_CYL    = ADDR_W + $clog2(DIV_CYL);
    localparam int SH_WRAP   = ADDR_W + $clog2(DIV_WRAP);

    // ceil(2^sh / d): exact quotient for every address-wide dividend
    localparam longint unsigned M_STRIPE_L = ((64'd1 << SH_STRIPE) + DIV_STRIPE - 1) / DIV_STRIPE;
    localparam longint unsigned M_PAR_L    = ((64'd1 << SH_PAR) + DIV_PAR - 1) / DIV_PAR;
    localparam longint unsigned M_TRK_L    = ((64'd1 << SH_TRK) + DIV_TRK - 1) / DIV_TRK;
    localparam longint unsigned M_CYL_L    = ((64'd1 << SH_CYL) + DIV_CYL - 1) / DIV_CYL;
    localparam longint unsigned M_WRAP_L   = ((64'd1 << SH_WRAP) + DIV_WRAP - 1) / DIV_WRAP;

    localparam logic [MW-1:0] M_STRIPE = MW'(M_STRIPE_L);
    localparam logic [MW-1:0] M_PAR    = MW'(M_PAR_L);
    localparam logic [MW-1:0] M_TRK    = MW'(M_TRK_L);
    localparam logic [MW-1:0] M_CYL    = MW'(M_CYL_L);
    localparam logic [MW-1:0] M_WRAP   = MW'(M_WRAP_L);

    function automatic logic [ADDR_W-1:0] recip_div(
        input logic [ADDR_W-1:0] n,
        input logic [MW-1:0]     m,
        input int unsigned       sh
    );
        logic [PROD_W-1:0] p;
        p = PROD_W'(n) * PROD_W'(m);
        return ADDR_W'(p >> sh);
    endfunction

    // Handshake and pipeline control
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, job_valid_reg;
    logic job_valid_next;
    logic s0_ready, s1_ready, s2_ready, job_ready, job_load;
    logic out_fire, last_w;

    // Stage 0: input register
    logic [ADDR_W-1:0] s0_addr_reg;
    logic              s0_cmd_reg;

    // Stage 1: stripe number
    logic [ADDR_W-1:0] s1_addr_reg, s1_stripe_reg, s1_stripe_next;
    logic              s1_cmd_reg;

    // Stage 2: quotients and slot within the stripe
    logic [ADDR_W-1:0] s2_stripe_reg;
    logic [ADDR_W-1:0] s2_qpar_reg, s2_qtrk_reg, s2_qcyl_reg, s2_qwrap_reg;
    logic [ADDR_W-1:0] s2_qpar_next, s2_qtrk_next, s2_qcyl_next, s2_qwrap_next;
    logic [PW-1:0]     s2_slot_reg, s2_slot_next;
    logic              s2_cmd_reg;

    // Result register: decoded word and request sequencer
    logic              job_read_reg, job_read_next;
    logic [PW-1:0]     job_parity_reg, job_parity_next;
    logic [PW-1:0]     job_disk_reg, job_disk_next;
    logic [CW-1:0]     job_cyl_reg, job_cyl_next;
    logic [HW-1:0]     job_hd_reg, job_hd_next;
    logic [SW-1:0]     job_sec_reg, job_sec_next;
    phase_t            job_phase_reg, job_phase_next;
    logic [PW-1:0]     sel_disk;
    logic              wr_w;

    logic [STAMP_W-1:0] count_reg, count_next;

    assign out_fire  = job_valid_reg && !out_stall;
    assign job_ready = !job_valid_reg || (out_fire && last_w);
    assign job_load  = s2_valid_reg && job_ready;
    assign s2_ready  = !s2_valid_reg || job_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s0_ready  = !s0_valid_reg || s1_ready;
    assign in_stall  = !s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            job_valid_reg <= 1'b0;
            job_phase_reg <= PH_FIRST;
            count_reg     <= '0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            job_valid_reg <= job_valid_next;
            job_phase_reg <= job_phase_next;
            count_reg     <= count_next;
        end
    end

    // Stage datapath
    always_comb
    begin
        s1_stripe_next = recip_div(s0_addr_reg, M_STRIPE, SH_STRIPE);

        s2_qpar_next  = recip_div(s1_stripe_reg, M_PAR, SH_PAR);
        s2_qtrk_next  = recip_div(s1_stripe_reg, M_TRK, SH_TRK);
        s2_qcyl_next  = recip_div(s1_stripe_reg, M_CYL, SH_CYL);
        s2_qwrap_next = recip_div(s1_stripe_reg, M_WRAP, SH_WRAP);
        s2_slot_next  = PW'(s1_addr_reg - ADDR_W'(s1_stripe_reg * ADDR_W'(DATA_DISKS)));

        job_read_next   = (s2_cmd_reg == CMD_READ);
        job_parity_next = PW'(s2_stripe_reg - ADDR_W'(s2_qpar_reg * ADDR_W'(DATA_DISKS + 1)));
        job_sec_next    = SW'(s2_stripe_reg
                              - ADDR_W'(s2_qtrk_reg * ADDR_W'(SECTORS_PER_TRACK)));
        job_hd_next     = HW'(s2_qtrk_reg - ADDR_W'(s2_qcyl_reg * ADDR_W'(HEADS)));
        job_cyl_next    = CW'(s2_qcyl_reg - ADDR_W'(s2_qwrap_reg * ADDR_W'(CYLINDERS)));
        // data disk skips over the parity disk
        job_disk_next   = (job_parity_next <= s2_slot_reg) ? PW'(s2_slot_reg + 1'b1)
                                                           : s2_slot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_addr_reg <= address;
            s0_cmd_reg  <= cmd;
        end
        if (s1_ready && s0_valid_reg)
        begin
            s1_addr_reg   <= s0_addr_reg;
            s1_cmd_reg    <= s0_cmd_reg;
            s1_stripe_reg <= s1_stripe_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_stripe_reg <= s1_stripe_reg;
            s2_cmd_reg    <= s1_cmd_reg;
            s2_qpar_reg   <= s2_qpar_next;
            s2_qtrk_reg   <= s2_qtrk_next;
            s2_qcyl_reg   <= s2_qcyl_next;
            s2_qwrap_reg  <= s2_qwrap_next;
            s2_slot_reg   <= s2_slot_next;
        end
        if (job_load)
        begin
            job_read_reg   <= job_read_next;
            job_parity_reg <= job_parity_next;
            job_disk_reg   <= job_disk_next;
            job_cyl_reg    <= job_cyl_next;
            job_hd_reg     <= job_hd_next;
            job_sec_reg    <= job_sec_next;
        end
    end

    // Sequencer next state
    always_comb
    begin
        job_phase_next = job_phase_reg;
        job_valid_next = job_valid_reg;
        if (job_load)
        begin
            job_phase_next = PH_FIRST;
            job_valid_next = 1'b1;
        end
        else if (out_fire && last_w)
        begin
            job_phase_next = PH_FIRST;
            job_valid_next = 1'b0;
        end
        else if (out_fire)
        begin
            unique case (job_phase_reg)
                PH_FIRST:  job_phase_next = PH_SECOND;
                PH_SECOND: job_phase_next = PH_THIRD;
                PH_THIRD:  job_phase_next = PH_FIRST;
                default:   job_phase_next = PH_FIRST;
            endcase
        end
    end

    // Sequencer outputs: a read word gives one data read; a write word gives parity read, data read, data write
    always_comb
    begin
        sel_disk = job_disk_reg;
        wr_w     = 1'b0;
        last_w   = 1'b0;
        unique case (job_phase_reg)
            PH_FIRST:
            begin
                last_w   = job_read_reg;
                sel_disk = job_read_reg ? job_disk_reg : job_parity_reg;
            end
            PH_SECOND:
            begin
                last_w = 1'b0;
            end
            PH_THIRD:
            begin
                wr_w   = 1'b1;
                last_w = 1'b1;
            end
            default:
            begin
                last_w = 1'b1;
            end
        endcase
    end

    // advance the stamp once per delivered request
    assign count_next = out_fire ? STAMP_W'(count_reg + 1'b1) : count_reg;

    assign out_valid  = job_valid_reg;
    assign disk_index = DISK_W'(sel_disk);
    assign cylinder   = CYL_W'(job_cyl_reg);
    assign head       = HEAD_W'(job_hd_reg);
    assign sector     = SEC_W'(job_sec_reg);
    assign is_write   = wr_w;
    assign last       = last_w;
    assign stamp      = count_reg;

    `ASSERT_RST(stamp_step_a, clk, rst_n, out_fire |=> (stamp == STAMP_W'($past(stamp) + 1'b1)), "stamp did not advance by one after a delivered request")
    `ASSERT_RST(stamp_hold_a, clk, rst_n, !out_fire |=> $stable(stamp), "stamp moved without a delivered request")
    `ASSERT_RST(burst_cont_a, clk, rst_n, (out_fire && !last) |=> out_valid, "write burst broke off before its last request")

endmodule

`default_nettype wire
